FILE: hdl/aspc_pkg.sv
// ----------------------------------------------------------------------------
// aspc_pkg
// Shared types and constants of the acute set point checker: point layout,
// input and result words, action codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package aspc_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned NUM_COORDS  = 4;
  localparam int unsigned POINT_W     = COORD_W * NUM_COORDS;
  localparam int unsigned LIMIT_W     = 5;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned PROD_W      = 2 * DIFF_W;
  localparam int unsigned SUM_W       = PROD_W + 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(9);

  // action codes, code 3 behaves as a plain test
  localparam logic [1:0] ACT_TEST   = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // w in the low bits, z in the high bits
  typedef struct packed {
    logic [COORD_W-1:0] coord_z;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_w;
  } point_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] coord_w;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } in_word_t;

  typedef struct packed {
    logic                   accepted;
    logic [COUNT_OUT_W-1:0] stored_count;
    logic                   set_full;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_I,
    S_RD_J,
    S_V0,
    S_V1,
    S_V2,
    S_DRAIN0,
    S_DRAIN1,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/acute_set_point_checker_core.sv
// ----------------------------------------------------------------------------
// acute_set_point_checker_core
// Keeps a set of 4-D points and tests a candidate word against every pair:
// each triangle of candidate and pair must have three strictly acute angles.
// Input channel in_valid_i/in_ready_o carries one word (action, coordinates);
// action 0 tests, 1 tests and appends if accepted and below both the limit
// and MAX_POINTS, 2 clears the set. Output channel out_valid_o/out_ready_i
// returns one word per input word (accepted, stored_count, set_full) from an
// output register. A test passes S_RD_I, S_RD_J, S_V0 to S_V2 (three vertices
// per pair), S_DRAIN0 and S_DRAIN1 to S_FINISH; a clear or a set below two
// points goes straight to S_FINISH. One shared dot-product unit takes one
// vertex per cycle. in_ready_o is high only while the sequencer is idle, one
// word at a time. If the receiver stalls, the finished word waits until the
// output register frees up. cfg_we_i/cfg_wdata_i write set_limit (reset 9);
// the user must write it only while idle, the block does not enforce this.
// Reset empties the set; store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module acute_set_point_checker_core
  import aspc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_word_t           in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_word_t               out_word_o,
  input  wire logic               cfg_we_i,
  input  wire logic [LIMIT_W-1:0] cfg_wdata_i
);

  localparam int unsigned IW   = $clog2(MAX_POINTS);
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

  state_e             state_q, state_d;
  logic [IW-1:0]      i_q, i_d, j_q, j_d;
  logic [CW-1:0]      count_q, count_d;
  logic               ok_q, ok_d;
  logic [LIMIT_W-1:0] limit_q;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, out_word_d;
  point_t             cand_q, cand_d;
  logic [1:0]         action_q, action_d;
  point_t             pa_q, pa_d;

  logic               mem_we;
  logic [IW-1:0]      rd_addr;
  point_t             rd_data;

  logic               issue;
  point_t             dot_a, dot_v, dot_c;
  logic               dot_valid, dot_pos;

  logic               accepted, room, do_app, full, fire;
  logic [CW-1:0]      j_next, i_next2;
  logic [CMPW-1:0]    count_ext;

  aspc_point_mem #(
    .DEPTH (MAX_POINTS),
    .IW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (cand_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  aspc_dot_unit u_dot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .pt_a_i      (dot_a),
    .pt_v_i      (dot_v),
    .pt_c_i      (dot_c),
    .res_valid_o (dot_valid),
    .res_pos_o   (dot_pos)
  );

  assign accepted = (action_q != ACT_CLEAR) && ok_q;
  assign room     = (CMPW'(count_q) < CMPW'(limit_q)) && (CMPW'(count_q) < CMPW'(MAX_POINTS));
  assign do_app   = (action_q == ACT_APPEND) && accepted && room;
  assign full     = (action_q == ACT_APPEND) && accepted && !room;
  assign fire     = !out_valid_q || out_ready_i;
  assign j_next   = CW'(j_q) + CW'(1);
  assign i_next2  = CW'(i_q) + CW'(2);

  // vertex order per pair: at stored point i, at stored point j, at candidate
  always_comb begin
    dot_a = cand_q;
    dot_v = pa_q;
    dot_c = rd_data;
    case (state_q)
      S_V1: begin
        dot_a = pa_q;
        dot_v = rd_data;
        dot_c = cand_q;
      end
      S_V2: begin
        dot_a = rd_data;
        dot_v = cand_q;
        dot_c = pa_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    count_d     = count_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    cand_d      = cand_q;
    action_d    = action_q;
    pa_d        = pa_q;
    rd_addr     = j_q;
    issue       = 1'b0;
    mem_we      = 1'b0;
    count_ext   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (dot_valid) begin
      ok_d = ok_q & dot_pos;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          action_d = in_word_i.action;
          cand_d   = '{coord_z: in_word_i.coord_z, coord_y: in_word_i.coord_y,
                       coord_x: in_word_i.coord_x, coord_w: in_word_i.coord_w};
          ok_d     = 1'b1;
          i_d      = '0;
          j_d      = IW'(1);
          if (in_word_i.action == ACT_CLEAR || count_q < CW'(2)) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_RD_I;
          end
        end
      end
      S_RD_I: begin
        rd_addr = i_q;
        state_d = S_RD_J;
      end
      S_RD_J: begin
        rd_addr = j_q;
        pa_d    = rd_data;
        state_d = S_V0;
      end
      S_V0: begin
        issue   = 1'b1;
        state_d = S_V1;
      end
      S_V1: begin
        issue   = 1'b1;
        state_d = S_V2;
      end
      S_V2: begin
        issue = 1'b1;
        if (j_next < count_q) begin
          // next j, same i: prefetch store[j+1]
          j_d     = j_next[IW-1:0];
          rd_addr = j_next[IW-1:0];
          state_d = S_V0;
        end else if (i_next2 < count_q) begin
          i_d     = i_q + IW'(1);
          j_d     = i_next2[IW-1:0];
          rd_addr = i_q + IW'(1);
          state_d = S_RD_J;
        end else begin
          state_d = S_DRAIN0;
        end
      end
      S_DRAIN0: begin
        state_d = S_DRAIN1;
      end
      S_DRAIN1: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (fire) begin
          if (action_q == ACT_CLEAR) begin
            count_d = '0;
          end else if (do_app) begin
            count_d = count_q + CW'(1);
            mem_we  = 1'b1;
          end
          count_ext               = CMPW'(count_d);
          out_word_d.accepted     = accepted;
          out_word_d.stored_count = count_ext[COUNT_OUT_W-1:0];
          out_word_d.set_full     = full;
          out_valid_d             = 1'b1;
          state_d                 = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      limit_q     <= LIMIT_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    ok_q       <= ok_d;
    out_word_q <= out_word_d;
    cand_q     <= cand_d;
    action_q   <= action_d;
    pa_q       <= pa_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

FILE: hdl/aspc_point_mem.sv
// ----------------------------------------------------------------------------
// aspc_point_mem
// Point store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aspc_point_mem
  import aspc_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [IW-1:0] waddr_i,
  input  wire point_t        wdata_i,
  input  wire logic [IW-1:0] raddr_i,
  output point_t             rdata_o
);

  point_t mem [DEPTH];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/aspc_dot_unit.sv
// ----------------------------------------------------------------------------
// aspc_dot_unit
// Shared vertex test: dot product of (a - v) and (c - v) over four coords,
// two pipeline stages, one vertex issued per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aspc_dot_unit
  import aspc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   issue_i,
  input  wire point_t pt_a_i,
  input  wire point_t pt_v_i,
  input  wire point_t pt_c_i,
  output logic        res_valid_o,
  output logic        res_pos_o
);

  logic signed [DIFF_W-1:0] d1 [NUM_COORDS];
  logic signed [DIFF_W-1:0] d2 [NUM_COORDS];
  logic signed [PROD_W-1:0] prod_d [NUM_COORDS];
  logic signed [PROD_W-1:0] prod_q [NUM_COORDS];
  logic signed [SUM_W-1:0]  sum;
  logic                     v1_q, v2_q, pos_q;

  always_comb begin
    for (int k = 0; k < NUM_COORDS; k++) begin
      d1[k] = signed'({1'b0, pt_a_i[k*COORD_W +: COORD_W]})
            - signed'({1'b0, pt_v_i[k*COORD_W +: COORD_W]});
      d2[k] = signed'({1'b0, pt_c_i[k*COORD_W +: COORD_W]})
            - signed'({1'b0, pt_v_i[k*COORD_W +: COORD_W]});
      prod_d[k] = PROD_W'(d1[k]) * PROD_W'(d2[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_COORDS; k++) begin
      prod_q[k] <= prod_d[k];
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < NUM_COORDS; k++) begin
      sum = sum + SUM_W'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= (sum != '0) && !sum[SUM_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
    end
  end

  assign res_valid_o = v2_q;
  assign res_pos_o   = pos_q;

endmodule

`default_nettype wire
